/* rtl/core/shvd_pkg.sv */
// Shared types and constants for the vertex dedup hash table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package shvd_pkg;
    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Y = 32'd19349663;
    localparam logic [31:0] PRIME_Z = 32'd83492791;
    localparam int unsigned SCRAMBLE_SHIFT = 17;
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        scramble_word = k ^ (k >> SCRAMBLE_SHIFT);
    endfunction
endpackage
`default_nettype wire

/* rtl/core/shvd_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module shvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/shvd_front.sv */
// Front end: accepts commands, computes the scrambled hash in two stages and
// pushes hashed items into a small queue. Depends on shvd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module shvd_front #(
    parameter int INDEX_BITS = 16,
    parameter int QDEPTH = 2
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire                  i_cmd,
    input  wire [15:0]           i_vertex_index,
    input  wire [31:0]           i_pos_x,
    input  wire [31:0]           i_pos_y,
    input  wire [31:0]           i_pos_z,
    // queue read side
    output logic                 o_q_valid,
    input  wire                  i_q_pop,
    output logic                 o_q_cmd,
    output logic [INDEX_BITS-1:0] o_q_vidx,
    output logic [31:0]          o_q_x,
    output logic [31:0]          o_q_y,
    output logic [31:0]          o_q_z,
    output logic [31:0]          o_q_hash
);
    localparam int QW = $clog2(QDEPTH);
    localparam int ENTRY_W = 1 + INDEX_BITS + 96 + 32;

    // stage 1: products
    logic              r_s1_valid;
    logic              r_s1_cmd;
    logic [INDEX_BITS-1:0] r_s1_vidx;
    logic [31:0]       r_s1_x, r_s1_y, r_s1_z;
    logic [31:0]       r_s1_hx, r_s1_hy, r_s1_hz;
    logic [QW:0]       r_count;
    logic [QW-1:0]     r_wp, r_rp;
    logic [ENTRY_W-1:0] r_q [QDEPTH];
    logic              s1_push;
    logic [INDEX_BITS-1:0] vidx_in;

    // stall when the hash stage and queue could overflow
    assign o_stall = (r_count + {{QW{1'b0}}, r_s1_valid}) >= (QW+1)'(QDEPTH);
    assign s1_push = r_s1_valid;

    generate
        if (INDEX_BITS >= 16) begin : g_wide
            assign vidx_in = INDEX_BITS'(i_vertex_index);
        end else begin : g_narrow
            assign vidx_in = i_vertex_index[INDEX_BITS-1:0];
        end
    endgenerate

    // hash stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid && !o_stall;
        end
        if (i_valid && !o_stall) begin
            r_s1_cmd  <= i_cmd;
            r_s1_vidx <= vidx_in;
            r_s1_x    <= i_pos_x;
            r_s1_y    <= i_pos_y;
            r_s1_z    <= i_pos_z;
            r_s1_hx   <= shvd_pkg::scramble_word(i_pos_x) * shvd_pkg::PRIME_X;
            r_s1_hy   <= shvd_pkg::scramble_word(i_pos_y) * shvd_pkg::PRIME_Y;
            r_s1_hz   <= shvd_pkg::scramble_word(i_pos_z) * shvd_pkg::PRIME_Z;
        end
    end

    // queue of hashed items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
        end else begin
            if (s1_push) begin
                r_wp <= (r_wp == QW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= (r_rp == QW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + {{QW{1'b0}}, s1_push} - {{QW{1'b0}}, i_q_pop};
        end
        if (s1_push) begin
            r_q[r_wp] <= {r_s1_cmd, r_s1_vidx, r_s1_x, r_s1_y, r_s1_z,
                          r_s1_hx ^ r_s1_hy ^ r_s1_hz};
        end
    end

    assign o_q_valid = r_count != '0;
    assign {o_q_cmd, o_q_vidx, o_q_x, o_q_y, o_q_z, o_q_hash} = r_q[r_rp];

    // queue never overflows or underflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QW+1)'(QDEPTH))
        else $error("front queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid)
        else $error("front queue pop while empty");
endmodule
`default_nettype wire

/* rtl/core/shvd_back.sv */
// Back end: probes the table quadratically, inserts on a miss for an insert command
// and holds the result in an output register. Depends on shvd_pkg and shvd_ram.
`timescale 1ns / 1ps
`default_nettype none
module shvd_back #(
    parameter int MAX_BUCKETS = 4096,
    parameter int INDEX_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire [3:0]             i_log_buckets,
    input  wire                   i_q_valid,
    output logic                  o_q_pop,
    input  wire                   i_q_cmd,
    input  wire [INDEX_BITS-1:0]  i_q_vidx,
    input  wire [31:0]            i_q_x,
    input  wire [31:0]            i_q_y,
    input  wire [31:0]            i_q_z,
    input  wire [31:0]            i_q_hash,
    output logic                  o_valid,
    input  wire                   i_stall,
    output logic                  o_found,
    output logic [15:0]           o_unique_index,
    output logic                  o_table_full
);
    localparam int AW = $clog2(MAX_BUCKETS);
    localparam int LMAX = AW;
    localparam int DW = 96 + INDEX_BITS;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr;
    logic [AW:0]        r_probe;
    logic [AW-1:0]      r_bucket;
    logic [AW-1:0]      r_mask;
    logic               r_cmd;
    logic [INDEX_BITS-1:0] r_vidx;
    logic [31:0]        r_x, r_y, r_z;
    logic               vld_rd;
    logic [DW-1:0]      data_rd;
    logic               we_v, we_d;
    logic [AW-1:0]      waddr;
    logic               wval;
    logic [4:0]         lb_sat;
    logic [AW-1:0]      mask_c;
    logic               hit, empty, last;
    logic [15:0]        vidx16, rd16;

    // saturate the bucket log and build the mask
    always_comb begin
        lb_sat = (32'(i_log_buckets) > LMAX) ? 5'(LMAX) : {1'b0, i_log_buckets};
        mask_c = AW'((({(AW+1){1'b0}} | 1'b1) << lb_sat) - 1'b1);
    end

    generate
        if (INDEX_BITS >= 16) begin : g_w
            assign vidx16 = r_vidx[15:0];
            assign rd16   = data_rd[15:0];
        end else begin : g_n
            assign vidx16 = 16'(r_vidx);
            assign rd16   = 16'(data_rd[INDEX_BITS-1:0]);
        end
    endgenerate

    // valid bits and slot data
    assign we_v  = (r_state == S_CLEAR) || (r_state == S_CHECK && empty && r_cmd == shvd_pkg::CMD_INSERT);
    assign we_d  = (r_state == S_CHECK) && empty && (r_cmd == shvd_pkg::CMD_INSERT);
    assign waddr = (r_state == S_CLEAR) ? r_clr : r_bucket;
    assign wval  = r_state != S_CLEAR;

    shvd_ram #(.WIDTH(1), .DEPTH(MAX_BUCKETS)) u_valid (
        .i_clk(i_clk), .i_we(we_v), .i_waddr(waddr), .i_wdata(wval),
        .i_raddr(r_bucket), .o_rdata(vld_rd));
    shvd_ram #(.WIDTH(DW), .DEPTH(MAX_BUCKETS)) u_data (
        .i_clk(i_clk), .i_we(we_d), .i_waddr(r_bucket),
        .i_wdata({r_x, r_y, r_z, r_vidx}),
        .i_raddr(r_bucket), .o_rdata(data_rd));

    assign empty = !vld_rd;
    assign hit   = vld_rd && data_rd[DW-1 -: 96] == {r_x, r_y, r_z};
    assign last  = r_probe == ({1'b0, r_mask});
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == AW'(MAX_BUCKETS-1)) n_state = S_IDLE;
            S_IDLE:  if (i_q_valid) n_state = S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                if (empty || hit || last) n_state = S_DONE;
                else n_state = S_READ;
            end
            S_DONE:  if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                r_cmd    <= i_q_cmd;
                r_vidx   <= i_q_vidx;
                r_x      <= i_q_x;
                r_y      <= i_q_y;
                r_z      <= i_q_z;
                r_mask   <= mask_c;
                r_bucket <= i_q_hash[AW-1:0] & mask_c;
                r_probe  <= '0;
            end
            S_CHECK: begin
                r_bucket <= (r_bucket + AW'(r_probe) + 1'b1) & r_mask;
                r_probe  <= r_probe + 1'b1;
                o_found        <= hit;
                o_table_full   <= !empty && !hit;
                o_unique_index <= hit ? rd16 :
                                  (empty && r_cmd == shvd_pkg::CMD_INSERT) ? vidx16 : 16'd0;
            end
            default: ;
        endcase
    end

    assign o_valid = r_state == S_DONE;

    // a result is never valid together with a full flag and a hit
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_found && o_table_full))
        else $error("found and full together");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped under stall");
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |-> r_probe <= {1'b0, r_mask})
        else $error("probe count past table size");
endmodule
`default_nettype wire

/* rtl/core/spatial_hash_vertex_dedup.sv */
// Top level of the vertex dedup hash table.
// Depends on shvd_pkg, shvd_front, shvd_back, shvd_ram.
//
// Usage:
//   Input channel i_valid/o_stall carries cmd (0 insert, 1 lookup), a
//   vertex index and three raw 32-bit position words. Output channel
//   o_valid/i_stall carries found, unique_index and table_full, one result
//   per item, in order.
//   The front hashes an item in one registered multiply stage and queues it
//   (two entries). The back probes one bucket at a time, a RAM read and then
//   a compare, and takes no new item until the result of the last one has
//   been accepted. After reset the back sweeps all MAX_BUCKETS entries of
//   the valid memory and takes no item until then; o_stall rises once the
//   queue fills.
//   log_buckets is written via i_cfg_we and resets to 12.
//   While the receiver stalls the result holds and the back waits; the
//   front keeps accepting until its queue is full.
`timescale 1ns / 1ps
`default_nettype none
module spatial_hash_vertex_dedup #(
    parameter int MAX_BUCKETS = 4096,
    parameter int INDEX_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [3:0]   i_cfg_wdata,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_cmd,
    input  wire [15:0]  i_vertex_index,
    input  wire [31:0]  i_pos_x,
    input  wire [31:0]  i_pos_y,
    input  wire [31:0]  i_pos_z,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_found,
    output logic [15:0] o_unique_index,
    output logic        o_table_full
);
    logic [3:0]  r_log_buckets;
    logic        q_valid, q_pop, q_cmd;
    logic [INDEX_BITS-1:0] q_vidx;
    logic [31:0] q_x, q_y, q_z, q_hash;

    // hold the bucket log register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_buckets <= 4'd12;
        end else if (i_cfg_we) begin
            r_log_buckets <= i_cfg_wdata;
        end
    end

    shvd_front #(.INDEX_BITS(INDEX_BITS), .QDEPTH(2)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_vertex_index(i_vertex_index),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_cmd(q_cmd), .o_q_vidx(q_vidx),
        .o_q_x(q_x), .o_q_y(q_y), .o_q_z(q_z), .o_q_hash(q_hash));

    shvd_back #(.MAX_BUCKETS(MAX_BUCKETS), .INDEX_BITS(INDEX_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_log_buckets(r_log_buckets),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_cmd(q_cmd), .i_q_vidx(q_vidx),
        .i_q_x(q_x), .i_q_y(q_y), .i_q_z(q_z), .i_q_hash(q_hash),
        .o_valid(o_valid), .i_stall(i_stall), .o_found(o_found),
        .o_unique_index(o_unique_index), .o_table_full(o_table_full));

    // a result only ever leaves with a sane flag set
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> o_unique_index == 16'd0)
        else $error("full result carries an index");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_log_buckets == $past(i_cfg_wdata))
        else $error("config write lost");
    // hold the result fields while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable({o_found, o_unique_index, o_table_full}))
        else $error("result changed under stall");
endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the spatial hash vertex dedup table.
// Drives insert and lookup transfers, predicts each result and checks it.
// Depends on shvd_pkg and spatial_hash_vertex_dedup.
`timescale 1ns / 1ps

class dedup_scoreboard;
    localparam int NBUCKETS = 4096;

    bit          slot_used [NBUCKETS];
    logic [31:0] slot_x    [NBUCKETS];
    logic [31:0] slot_y    [NBUCKETS];
    logic [31:0] slot_z    [NBUCKETS];
    logic [15:0] slot_idx  [NBUCKETS];
    logic [3:0]  log_buckets;
    logic [17:0] pending_results[$];
    int          fail_count;

    function new();
        log_buckets = 4'd12;
        fail_count = 0;
    endfunction

    function automatic logic [31:0] mix(logic [31:0] k, logic [31:0] prime);
        logic [31:0] s;
        s = k ^ (k >> 17);
        return s * prime;
    endfunction

    // Hash, probe quadratically and update the table as the block does.
    function void note_transfer(logic cmd, logic [15:0] vidx,
                                logic [31:0] kx, logic [31:0] ky, logic [31:0] kz);
        logic [31:0] mask, bucket, h;
        logic        hit, full;
        logic [15:0] idx;
        int unsigned lb;
        lb = log_buckets;
        if (lb > 12) lb = 12;
        mask = (32'd1 << lb) - 1;
        h = mix(kx, shvd_pkg::PRIME_X) ^ mix(ky, shvd_pkg::PRIME_Y)
            ^ mix(kz, shvd_pkg::PRIME_Z);
        bucket = h & mask;
        hit = 0; idx = 0; full = 1;
        for (longint p = 0; p <= mask; p++) begin
            if (!slot_used[bucket]) begin
                if (cmd == shvd_pkg::CMD_INSERT) begin
                    slot_used[bucket] = 1;
                    slot_x[bucket] = kx; slot_y[bucket] = ky; slot_z[bucket] = kz;
                    slot_idx[bucket] = vidx;
                    idx = vidx;
                end
                full = 0;
                break;
            end
            if (slot_x[bucket] == kx && slot_y[bucket] == ky && slot_z[bucket] == kz) begin
                hit = 1; idx = slot_idx[bucket]; full = 0;
                break;
            end
            bucket = (bucket + p[31:0] + 1) & mask;
        end
        pending_results.push_back({hit, idx, full});
    endfunction

    function void check_result(logic found, logic [15:0] uidx, logic full);
        logic [17:0] want;
        if (pending_results.size() == 0) begin
            $error("result with no expectation: found=%0d index=%0d full=%0d",
                   found, uidx, full);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        if (found !== want[17]) begin
            $error("found: expected %0d actual %0d", want[17], found); fail_count++;
        end
        if (uidx !== want[16:1]) begin
            $error("unique_index: expected %0d actual %0d", want[16:1], uidx); fail_count++;
        end
        if (full !== want[0]) begin
            $error("table_full: expected %0d actual %0d", want[0], full); fail_count++;
        end
    endfunction
endclass

module tb_top;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [3:0]  cfg_wdata = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        cmd = 0;
    logic [15:0] vidx = 0;
    logic [31:0] px = 0, py = 0, pz = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        found, full;
    logic [15:0] uidx;

    dedup_scoreboard sb = new();
    bit   hold_off = 0;
    int   idle_cycles = 0;
    // Recently used positions, reused to produce hits.
    logic [95:0] recent_pos[$];

    always #5 clk = ~clk;

    spatial_hash_vertex_dedup u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_stall(in_stall), .i_cmd(cmd), .i_vertex_index(vidx),
        .i_pos_x(px), .i_pos_y(py), .i_pos_z(pz),
        .o_valid(out_valid), .i_stall(out_stall), .o_found(found),
        .o_unique_index(uidx), .o_table_full(full)
    );

    // Check accepted results; count cycles without any transfer.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(found, uidx, full);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Draw a wait after each result transfer, with a long hold-off on request.
    initial begin
        int w;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_stall <= 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
                out_stall <= 0;
            end else if (out_valid && !out_stall) begin
                w = $urandom_range(0, 2) == 0 ? $urandom_range(0, 14) : 0;
                if (w > 0) begin
                    out_stall <= 1;
                    repeat (w) @(posedge clk);
                    out_stall <= 0;
                end
            end
        end
    end

    // Drive one transfer; valid stays high when the next one follows at once.
    task automatic send(logic c, logic [15:0] v, logic [31:0] x, logic [31:0] y,
                        logic [31:0] z, int gap);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1; cmd <= c; vidx <= v; px <= x; py <= y; pz <= z;
        do @(posedge clk); while (in_stall);
        sb.note_transfer(c, v, x, y, z);
        recent_pos.push_back({x, y, z});
        if (recent_pos.size() > 64) void'(recent_pos.pop_front());
    endtask

    task automatic drain_and_config(logic [3:0] lb);
        in_valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1; cfg_wdata <= lb;
        @(posedge clk);
        cfg_we <= 0;
        sb.log_buckets = lb;
    endtask

    task automatic random_item(int gap);
        logic [95:0] p;
        logic        c;
        c = $urandom_range(0, 3) == 0;
        if (recent_pos.size() > 0 && $urandom_range(0, 2) == 0)
            p = recent_pos[$urandom_range(0, recent_pos.size() - 1)];
        else if ($urandom_range(0, 1))
            p = {$urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7)}
                << 0;
        else
            p = {$urandom, $urandom, $urandom};
        send(c, 16'($urandom), p[95:64], p[63:32], p[31:0], $urandom_range(0, 14) > 9 ?
             $urandom_range(0, 14) : 0);
    endtask

    initial begin
        logic [3:0] settings[6];
        settings = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd12, 4'd6};
        repeat (4) @(posedge clk);
        rst_n <= 1;
        // Directed: extremes, both commands, hit, lookup miss, all-ones index.
        send(shvd_pkg::CMD_LOOKUP, 16'd5, 0, 0, 0, 0);
        send(shvd_pkg::CMD_INSERT, 16'hFFFF, 0, 0, 0, 0);
        send(shvd_pkg::CMD_INSERT, 16'd7, 0, 0, 0, 0);
        send(shvd_pkg::CMD_LOOKUP, 16'd0, 0, 0, 0, 0);
        send(shvd_pkg::CMD_INSERT, 16'd0, '1, '1, '1, 0);
        send(shvd_pkg::CMD_LOOKUP, 16'd1, '1, '1, '1, 3);
        send(shvd_pkg::CMD_INSERT, 16'h8000, 32'h3F800000, 32'hBF800000, 32'h80000000, 0);
        send(shvd_pkg::CMD_LOOKUP, 16'h1234, 32'hAAAAAAAA, 32'h55555555, 32'h0001FFFF, 0);
        // Sweep the bucket log settings; the small tables fill up and hit the full-table case.
        foreach (settings[s]) begin
            drain_and_config(settings[s]);
            for (int i = 0; i < 6; i++)
                send(i[0], i[15:0] + 16'd100, i + 32'd50, 32'd1, 32'd2, 0);
            if (s == 2) hold_off = 1;
            for (int i = 0; i < 300; i++) random_item(0);
        end
        in_valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* files.f */
rtl/core/shvd_pkg.sv
rtl/core/shvd_ram.sv
rtl/core/shvd_front.sv
rtl/core/shvd_back.sv
rtl/core/spatial_hash_vertex_dedup.sv
verif/tb_top.sv
